FILE: hdl/p2va_pkg.sv
// ============================================================================
// p2va_pkg: shared types and constants of the pixel to view angle block
// Fixed point limits, register indexes, beat types and the arctangent table.
// ============================================================================
package p2va_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int DIV_STAGES      = 16;

    localparam logic signed [48:0] BIAS_Q16     = 49'sd655;
    localparam logic signed [32:0] AIM_DROP_Q24 = 33'sd55364813;
    localparam logic [31:0]        NORM_LIMIT   = 32'd16777215;
    localparam logic [32:0]        RAD_LIMIT    = 33'd33554432;
    localparam logic signed [48:0] TAN_LIMIT    = 49'sd2147483647;
    localparam logic [17:0]        FOCAL_MIN    = 18'd16;

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_DIST_K1  = 3'd4,
        REG_DIST_K2  = 3'd5,
        REG_DIST_P1  = 3'd6,
        REG_DIST_P2  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [17:0]        focal_x;
        logic [17:0]        focal_y;
        logic [15:0]        center_x;
        logic [15:0]        center_y;
        logic signed [19:0] dist_k1;
        logic signed [19:0] dist_k2;
        logic signed [19:0] dist_p1;
        logic signed [19:0] dist_p2;
    } cam_cfg_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } pix_beat_t;

    typedef struct packed {
        logic signed [24:0] norm_x;
        logic signed [24:0] norm_y;
    } norm_beat_t;

    typedef struct packed {
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
    } tan_beat_t;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] pitch_aim_angle;
    } ang_beat_t;

    // atan(2^-i) in degrees, Q.24.
    function automatic logic signed [31:0] atan_deg_q24(input int idx);
        logic signed [31:0] v;
        unique case (idx)
            0:       v = 32'sd754974720;
            1:       v = 32'sd445687602;
            2:       v = 32'sd235489089;
            3:       v = 32'sd119537938;
            4:       v = 32'sd60000934;
            5:       v = 32'sd30029717;
            6:       v = 32'sd15018523;
            7:       v = 32'sd7509720;
            8:       v = 32'sd3754917;
            9:       v = 32'sd1877466;
            10:      v = 32'sd938734;
            11:      v = 32'sd469367;
            12:      v = 32'sd234684;
            13:      v = 32'sd117342;
            14:      v = 32'sd58671;
            15:      v = 32'sd29335;
            16:      v = 32'sd14668;
            17:      v = 32'sd7334;
            18:      v = 32'sd3667;
            19:      v = 32'sd1833;
            20:      v = 32'sd917;
            21:      v = 32'sd458;
            22:      v = 32'sd229;
            23:      v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/p2va_if.sv
// ============================================================================
// p2va_if: stream interfaces of the pixel to view angle block
// Target pixel beats in, view angle beats out, valid/ready handshake.
// ============================================================================
interface p2va_target_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface p2va_angle_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] pitch_aim_angle;

    modport source (output valid, output yaw_angle, output pitch_angle,
                    output pitch_aim_angle, input ready);
    modport sink (input valid, input yaw_angle, input pitch_angle,
                  input pitch_aim_angle, output ready);
endinterface

FILE: hdl/p2va_norm_div.sv
// ============================================================================
// p2va_norm_div: principal point offset and focal length division
// Radix-4 restoring divider, two quotient bits per stage, both axes at once.
// ============================================================================
module p2va_norm_div
    import p2va_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cam_cfg_t   cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  pix_beat_t  up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output norm_beat_t dn_data
);

    localparam int NST = DIV_STAGES + 2;

    typedef struct packed {
        logic        neg;
        logic [31:0] num;
        logic [17:0] rem;
        logic [31:0] quo;
    } div_lane_t;

    function automatic div_lane_t div_prep(input logic [15:0] pix, input logic [15:0] ctr);
        div_lane_t          r;
        logic signed [16:0] d;
        logic [16:0]        mag;
        d     = $signed({1'b0, pix}) - $signed({1'b0, ctr});
        mag   = d[16] ? 17'(-d) : 17'(d);
        r.neg = d[16];
        r.num = {mag[15:0], 16'd0};
        r.rem = 18'd0;
        r.quo = 32'd0;
        return r;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t l, input logic [17:0] dv);
        div_lane_t   r;
        logic [18:0] trial;
        r = l;
        for (int b = 0; b < 2; b++) begin
            trial = {r.rem, r.num[31]};
            r.num = {r.num[30:0], 1'b0};
            if (trial >= {1'b0, dv}) begin
                r.rem = 18'(trial - {1'b0, dv});
                r.quo = {r.quo[30:0], 1'b1};
            end
            else begin
                r.rem = trial[17:0];
                r.quo = {r.quo[30:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [24:0] div_finish(input div_lane_t l);
        logic [23:0] q;
        q = (l.quo > NORM_LIMIT) ? NORM_LIMIT[23:0] : l.quo[23:0];
        return l.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    div_lane_t          lx_reg [0:DIV_STAGES];
    div_lane_t          ly_reg [0:DIV_STAGES];
    logic signed [24:0] nx_reg;
    logic signed [24:0] ny_reg;
    logic [NST-1:0]     vld_reg;
    logic [NST-1:0]     en;
    logic [17:0]        div_x;
    logic [17:0]        div_y;

    // Focal lengths below FOCAL_MIN (16 pixels) are treated as FOCAL_MIN.
    assign div_x = (cfg.focal_x < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_x;
    assign div_y = (cfg.focal_y < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_y;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign up_ready       = en[0];
    assign dn_valid       = vld_reg[NST-1];
    assign dn_data.norm_x = nx_reg;
    assign dn_data.norm_y = ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? up_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lx_reg[0] <= div_prep(up_data.pixel_x, cfg.center_x);
            ly_reg[0] <= div_prep(up_data.pixel_y, cfg.center_y);
        end
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            if (en[i])
            begin
                lx_reg[i] <= div_step(lx_reg[i-1], div_x);
                ly_reg[i] <= div_step(ly_reg[i-1], div_y);
            end
        end
        if (en[NST-1])
        begin
            nx_reg <= div_finish(lx_reg[DIV_STAGES]);
            ny_reg <= div_finish(ly_reg[DIV_STAGES]);
        end
    end

endmodule

FILE: hdl/p2va_distort.sv
// ============================================================================
// p2va_distort: radial and tangential distortion of normalized coordinates
// Eight stages, at most one multiplier level each, giving the Q.16 tangents.
// ============================================================================
module p2va_distort
    import p2va_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cam_cfg_t   cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  norm_beat_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output tan_beat_t  dn_data
);

    localparam int NST = 8;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    // Stage 0: squares and cross product.
    logic signed [24:0] x0_reg, y0_reg;
    logic [31:0]        xx0_reg, yy0_reg;
    logic signed [32:0] xy0_reg;
    // Stage 1: radius terms.
    logic signed [24:0] x1_reg, y1_reg;
    logic signed [32:0] xy1_reg;
    logic [25:0]        rc1_reg;
    logic [33:0]        r2x1_reg, r2y1_reg;
    // Stage 2: first radial term and clamped radius squared.
    logic signed [24:0] x2_reg, y2_reg;
    logic signed [32:0] xy2_reg;
    logic [33:0]        r2x2_reg, r2y2_reg;
    logic signed [30:0] k1t2_reg;
    logic [35:0]        rcc2_reg;
    // Stage 3: second radial term.
    logic signed [24:0] x3_reg, y3_reg;
    logic signed [32:0] xy3_reg;
    logic [33:0]        r2x3_reg, r2y3_reg;
    logic signed [30:0] k1t3_reg;
    logic signed [40:0] k2t3_reg;
    // Stage 4: distortion factor.
    logic signed [24:0] x4_reg, y4_reg;
    logic signed [32:0] xy4_reg;
    logic [33:0]        r2x4_reg, r2y4_reg;
    logic signed [41:0] fac4_reg;
    // Stage 5: products in Q.32.
    logic signed [63:0] xf5_reg, yf5_reg;
    logic signed [52:0] pxa5_reg, pya5_reg;
    logic signed [54:0] qx5_reg, qy5_reg;
    // Stage 6 and 7.
    logic signed [63:0] xd6_reg, yd6_reg;
    logic signed [31:0] tx7_reg, ty7_reg;

    logic signed [49:0] sq_x, sq_y, pr_xy;
    logic [32:0]        r2;
    logic signed [46:0] pr_k1;
    logic [51:0]        pr_rc;
    logic signed [56:0] pr_k2;
    logic signed [66:0] pr_xf, pr_yf;
    logic signed [52:0] pr_pxa, pr_pya;
    logic signed [54:0] pr_qx, pr_qy;

    function automatic logic signed [31:0] tan_clamp(input logic signed [63:0] d);
        logic signed [48:0] t;
        t = 49'(d >>> 16) + BIAS_Q16;
        if (t > TAN_LIMIT)
        begin
            t = TAN_LIMIT;
        end
        else if (t < -TAN_LIMIT)
        begin
            t = -TAN_LIMIT;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] tan_plain(input logic signed [63:0] d);
        logic signed [48:0] t;
        t = 49'(d >>> 16);
        if (t > TAN_LIMIT)
        begin
            t = TAN_LIMIT;
        end
        else if (t < -TAN_LIMIT)
        begin
            t = -TAN_LIMIT;
        end
        return t[31:0];
    endfunction

    always_comb
    begin
        sq_x   = up_data.norm_x * up_data.norm_x;
        sq_y   = up_data.norm_y * up_data.norm_y;
        pr_xy  = up_data.norm_x * up_data.norm_y;
        r2     = {1'b0, xx0_reg} + {1'b0, yy0_reg};
        pr_k1  = cfg.dist_k1 * $signed({1'b0, rc1_reg});
        pr_rc  = rc1_reg * rc1_reg;
        pr_k2  = cfg.dist_k2 * $signed({1'b0, rcc2_reg});
        pr_xf  = x4_reg * fac4_reg;
        pr_yf  = y4_reg * fac4_reg;
        pr_pxa = cfg.dist_p1 * xy4_reg;
        pr_pya = cfg.dist_p2 * xy4_reg;
        pr_qx  = cfg.dist_p2 * $signed({1'b0, r2x4_reg});
        pr_qy  = cfg.dist_p1 * $signed({1'b0, r2y4_reg});
    end

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign up_ready      = en[0];
    assign dn_valid      = vld_reg[NST-1];
    assign dn_data.tan_x = tx7_reg;
    assign dn_data.tan_y = ty7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? up_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg  <= up_data.norm_x;
            y0_reg  <= up_data.norm_y;
            xx0_reg <= sq_x[47:16];
            yy0_reg <= sq_y[47:16];
            xy0_reg <= pr_xy[48:16];
        end
        if (en[1])
        begin
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            xy1_reg  <= xy0_reg;
            // Only the distortion factor sees the clamped radius.
            rc1_reg  <= (r2 > RAD_LIMIT) ? RAD_LIMIT[25:0] : r2[25:0];
            r2x1_reg <= {1'b0, r2} + {1'b0, xx0_reg, 1'b0};
            r2y1_reg <= {1'b0, r2} + {1'b0, yy0_reg, 1'b0};
        end
        if (en[2])
        begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            xy2_reg  <= xy1_reg;
            r2x2_reg <= r2x1_reg;
            r2y2_reg <= r2y1_reg;
            k1t2_reg <= pr_k1[46:16];
            rcc2_reg <= pr_rc[51:16];
        end
        if (en[3])
        begin
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            xy3_reg  <= xy2_reg;
            r2x3_reg <= r2x2_reg;
            r2y3_reg <= r2y2_reg;
            k1t3_reg <= k1t2_reg;
            k2t3_reg <= pr_k2[56:16];
        end
        if (en[4])
        begin
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            xy4_reg  <= xy3_reg;
            r2x4_reg <= r2x3_reg;
            r2y4_reg <= r2y3_reg;
            fac4_reg <= 42'sd65536 + 42'(k1t3_reg) + 42'(k2t3_reg);
        end
        if (en[5])
        begin
            xf5_reg  <= pr_xf[63:0];
            yf5_reg  <= pr_yf[63:0];
            pxa5_reg <= pr_pxa;
            pya5_reg <= pr_pya;
            qx5_reg  <= pr_qx;
            qy5_reg  <= pr_qy;
        end
        if (en[6])
        begin
            xd6_reg <= xf5_reg + (64'(pxa5_reg) <<< 1) + 64'(qx5_reg);
            yd6_reg <= yf5_reg + (64'(pya5_reg) <<< 1) + 64'(qy5_reg);
        end
        if (en[7])
        begin
            tx7_reg <= tan_plain(xd6_reg);
            ty7_reg <= tan_clamp(yd6_reg);
        end
    end

endmodule

FILE: hdl/p2va_cordic.sv
// ============================================================================
// p2va_cordic: pipelined CORDIC arctangent for yaw and pitch
// One rotation per stage, angle in degrees Q.24, rounded to the output format.
// ============================================================================
module p2va_cordic
    import p2va_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  tan_beat_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output ang_beat_t dn_data
);

    localparam int NST       = CORDIC_STAGES + 2;
    localparam int CW        = 50;
    localparam int OUT_SHIFT = 24 - ANGLE_FRAC_BITS;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [31:0]   z;
    } rot_t;

    function automatic rot_t rot_load(input logic signed [31:0] v);
        rot_t r;
        r.x = CW'(64'sd1 <<< 32);
        r.y = CW'(v) <<< 16;
        r.z = 32'sd0;
        return r;
    endfunction

    function automatic rot_t rot_step(input rot_t a, input int s);
        rot_t                 r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = a.x >>> s;
        ys = a.y >>> s;
        if (!a.y[CW-1])
        begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + atan_deg_q24(s);
        end
        else
        begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - atan_deg_q24(s);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [32:0] z);
        logic signed [33:0] r;
        r = (34'(z) + (34'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > 34'sd32767)
        begin
            r = 34'sd32767;
        end
        else if (r < -34'sd32768)
        begin
            r = -34'sd32768;
        end
        return r[15:0];
    endfunction

    rot_t           yaw_reg   [0:CORDIC_STAGES];
    rot_t           pitch_reg [0:CORDIC_STAGES];
    ang_beat_t      out_reg;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NST-1];
    assign dn_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? up_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            yaw_reg[0]   <= rot_load(up_data.tan_x);
            pitch_reg[0] <= rot_load(up_data.tan_y);
        end
        for (int i = 1; i <= CORDIC_STAGES; i++)
        begin
            if (en[i])
            begin
                yaw_reg[i]   <= rot_step(yaw_reg[i-1], i - 1);
                pitch_reg[i] <= rot_step(pitch_reg[i-1], i - 1);
            end
        end
        if (en[NST-1])
        begin
            out_reg.yaw_angle       <= to_out(33'(yaw_reg[CORDIC_STAGES].z));
            out_reg.pitch_angle     <= to_out(33'(pitch_reg[CORDIC_STAGES].z));
            // Aim pitch drops 3.3 degrees before rounding.
            out_reg.pitch_aim_angle <= to_out(33'(pitch_reg[CORDIC_STAGES].z) - AIM_DROP_Q24);
        end
    end

endmodule

FILE: hdl/pixel_to_view_angle.sv
// ============================================================================
// pixel_to_view_angle: target pixel position to yaw and pitch view angles
// Pinhole camera with Brown-Conrady distortion, fixed point, fully pipelined.
// ============================================================================
// The block takes one target pixel beat per clock while the pipeline has
// room and returns one angle beat for each, in order. A beat passes through
// the focal length divider, which retires two quotient bits per stage, the
// distortion polynomial, one multiplier level per stage, and the CORDIC
// rotations plus load and rounding. Every stage holds its own valid bit, so
// bubbles are squeezed out while the output is stalled and the block keeps
// taking beats until the pipeline is full. Camera registers sit on an APB
// port at byte address 4*i and must only be written while no beat is in
// flight.
module pixel_to_view_angle
    import p2va_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    p2va_target_if.sink  target,
    p2va_angle_if.source view
);

    logic [17:0]        focal_x_reg;
    logic [17:0]        focal_y_reg;
    logic [15:0]        center_x_reg;
    logic [15:0]        center_y_reg;
    logic signed [19:0] dist_k1_reg;
    logic signed [19:0] dist_k2_reg;
    logic signed [19:0] dist_p1_reg;
    logic signed [19:0] dist_p2_reg;

    cam_cfg_t   cfg;
    reg_idx_t   reg_idx;
    logic       cfg_write;
    pix_beat_t  pix_beat;
    norm_beat_t norm_beat;
    tan_beat_t  tan_beat;
    ang_beat_t  ang_beat;
    logic       norm_valid;
    logic       norm_ready;
    logic       tan_valid;
    logic       tan_ready;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register file. Coefficients are stored as signed Q3.16.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 18'd16384;
            focal_y_reg  <= 18'd16384;
            center_x_reg <= 16'd10240;
            center_y_reg <= 16'd5760;
            dist_k1_reg  <= '0;
            dist_k2_reg  <= '0;
            dist_p1_reg  <= '0;
            dist_p2_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FOCAL_X:  focal_x_reg  <= pwdata[17:0];
                REG_FOCAL_Y:  focal_y_reg  <= pwdata[17:0];
                REG_CENTER_X: center_x_reg <= pwdata[15:0];
                REG_CENTER_Y: center_y_reg <= pwdata[15:0];
                REG_DIST_K1:  dist_k1_reg  <= pwdata[19:0];
                REG_DIST_K2:  dist_k2_reg  <= pwdata[19:0];
                REG_DIST_P1:  dist_p1_reg  <= pwdata[19:0];
                REG_DIST_P2:  dist_p2_reg  <= pwdata[19:0];
            endcase
        end
    end

    // Read back; coefficients come back sign extended.
    always_comb
    begin
        unique case (reg_idx)
            REG_FOCAL_X:  prdata = {14'd0, focal_x_reg};
            REG_FOCAL_Y:  prdata = {14'd0, focal_y_reg};
            REG_CENTER_X: prdata = {16'd0, center_x_reg};
            REG_CENTER_Y: prdata = {16'd0, center_y_reg};
            REG_DIST_K1:  prdata = 32'(dist_k1_reg);
            REG_DIST_K2:  prdata = 32'(dist_k2_reg);
            REG_DIST_P1:  prdata = 32'(dist_p1_reg);
            REG_DIST_P2:  prdata = 32'(dist_p2_reg);
        endcase
    end

    assign cfg.focal_x  = focal_x_reg;
    assign cfg.focal_y  = focal_y_reg;
    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.dist_k1  = dist_k1_reg;
    assign cfg.dist_k2  = dist_k2_reg;
    assign cfg.dist_p1  = dist_p1_reg;
    assign cfg.dist_p2  = dist_p2_reg;

    assign pix_beat.pixel_x = target.pixel_x;
    assign pix_beat.pixel_y = target.pixel_y;

    // Normalize by principal point and focal length.
    p2va_norm_div u_norm_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (target.valid),
        .up_ready (target.ready),
        .up_data  (pix_beat),
        .dn_valid (norm_valid),
        .dn_ready (norm_ready),
        .dn_data  (norm_beat)
    );

    // Apply the distortion polynomial and the pitch bias.
    p2va_distort u_distort (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (norm_valid),
        .up_ready (norm_ready),
        .up_data  (norm_beat),
        .dn_valid (tan_valid),
        .dn_ready (tan_ready),
        .dn_data  (tan_beat)
    );

    // Arctangents in degrees and the final output register.
    p2va_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (tan_valid),
        .up_ready (tan_ready),
        .up_data  (tan_beat),
        .dn_valid (view.valid),
        .dn_ready (view.ready),
        .dn_data  (ang_beat)
    );

    assign view.yaw_angle       = ang_beat.yaw_angle;
    assign view.pitch_angle     = ang_beat.pitch_angle;
    assign view.pitch_aim_angle = ang_beat.pitch_aim_angle;

endmodule

FILE: bench/pixel_to_view_angle_tb.sv
// ============================================================================
// pixel_to_view_angle_tb: self-checking bench of the pixel to view angle block
// Drives target pixel beats with random gaps, stalls the angle output, and
// compares every angle beat with a fixed point prediction of the camera math.
// ============================================================================
module pixel_to_view_angle_tb;
    import p2va_pkg::*;

    // Expected angle beats in arrival order, with the camera settings that the
    // predictor works from.
    class angle_scoreboard;
        ang_beat_t pending[$];
        cam_cfg_t  cam;
        int        errors;

        function new();
            errors = 0;
            cam.focal_x  = 18'd16384;
            cam.focal_y  = 18'd16384;
            cam.center_x = 16'd10240;
            cam.center_y = 16'd5760;
            cam.dist_k1  = '0;
            cam.dist_k2  = '0;
            cam.dist_p1  = '0;
            cam.dist_p2  = '0;
        endfunction

        static function longint sat(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        static function longint to_norm(logic [15:0] pix, logic [15:0] ctr,
                                        logic [17:0] foc);
            longint d;
            longint f;
            d = longint'(pix) - longint'(ctr);
            f = (foc < FOCAL_MIN) ? 16 : longint'(foc);
            return sat((d * 65536) / f, 16777215);
        endfunction

        // Vectoring CORDIC, result in degrees Q.24.
        static function longint atan_deg(longint v);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            x = 64'sd1 <<< 32;
            y = v * 65536;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(atan_deg_q24(i));
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(atan_deg_q24(i));
                end
            end
            return z;
        endfunction

        static function logic [15:0] round_angle(longint z);
            longint r;
            int sh;
            sh = 24 - ANGLE_FRAC_BITS;
            r = (z + (64'sd1 <<< (sh - 1))) >>> sh;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r[15:0];
        endfunction

        function void note_target(logic [15:0] px, logic [15:0] py);
            longint x, y, xx, yy, xy, r2, rc, fac, xd, yd, tx, ty, pitch;
            longint k1, k2, p1, p2;
            ang_beat_t a;
            k1 = cam.dist_k1;
            k2 = cam.dist_k2;
            p1 = cam.dist_p1;
            p2 = cam.dist_p2;
            x  = to_norm(px, cam.center_x, cam.focal_x);
            y  = to_norm(py, cam.center_y, cam.focal_y);
            xx = (x * x) >>> 16;
            yy = (y * y) >>> 16;
            xy = (x * y) >>> 16;
            r2 = xx + yy;
            // Only the distortion factor sees the clamped radius.
            rc = (r2 > 33554432) ? 33554432 : r2;
            fac = 65536 + ((k1 * rc) >>> 16) + ((k2 * ((rc * rc) >>> 16)) >>> 16);
            xd = x * fac + p1 * xy * 2 + p2 * (r2 + 2 * xx);
            yd = y * fac + p2 * xy * 2 + p1 * (r2 + 2 * yy);
            tx = sat(xd >>> 16, 2147483647);
            ty = sat((yd >>> 16) + 655, 2147483647);
            pitch = atan_deg(ty);
            a.yaw_angle       = round_angle(atan_deg(tx));
            a.pitch_angle     = round_angle(pitch);
            a.pitch_aim_angle = round_angle(pitch - 55364813);
            pending = {pending, a};
        endfunction

        function void check_angle(ang_beat_t got);
            ang_beat_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected angle beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.yaw_angle !== want.yaw_angle ||
                got.pitch_angle !== want.pitch_angle ||
                got.pitch_aim_angle !== want.pitch_aim_angle)
            begin
                errors++;
                if (errors <= 10)
                    $display("angle mismatch: want yaw %0d pitch %0d aim %0d, got %0d %0d %0d",
                             want.yaw_angle, want.pitch_angle, want.pitch_aim_angle,
                             got.yaw_angle, got.pitch_angle, got.pitch_aim_angle);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    p2va_target_if target();
    p2va_angle_if  view();

    pixel_to_view_angle dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .target  (target.sink),
        .view    (view.source)
    );

    angle_scoreboard sb;
    bit              gaps_on;   // random idling on both sides

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Generous fixed limit: ~2000 beats with random gaps and stalls, plus the
    // pipeline depth, come far under this.
    initial
    begin
        #20000000;
        $display("pixel_to_view_angle_tb: done, errors");
        $finish;
    end

    // Output side: stalls come in bursts, and every accepted beat is checked
    // at the rising edge where the handshake happens.
    initial
    begin
        int n;
        view.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                view.ready <= 1'b0;
                repeat (n)
                    @(negedge clk);
            end
            view.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ang_beat_t got;
        if (rst_n && view.valid && view.ready)
        begin
            got.yaw_angle       = view.yaw_angle;
            got.pitch_angle     = view.pitch_angle;
            got.pitch_aim_angle = view.pitch_aim_angle;
            sb.check_angle(got);
        end
    end

    // A register write: setup cycle, then access cycle. The prediction takes
    // the new value at the edge where the access completes.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_FOCAL_X:  sb.cam.focal_x  = value[17:0];
            REG_FOCAL_Y:  sb.cam.focal_y  = value[17:0];
            REG_CENTER_X: sb.cam.center_x = value[15:0];
            REG_CENTER_Y: sb.cam.center_y = value[15:0];
            REG_DIST_K1:  sb.cam.dist_k1  = value[19:0];
            REG_DIST_K2:  sb.cam.dist_k2  = value[19:0];
            REG_DIST_P1:  sb.cam.dist_p1  = value[19:0];
            REG_DIST_P2:  sb.cam.dist_p2  = value[19:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One target beat; valid stays high across back to back beats.
    task automatic send_target(logic [15:0] px, logic [15:0] py);
        int n;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 11);
            target.valid <= 1'b0;
            repeat (n)
                @(negedge clk);
        end
        target.valid   <= 1'b1;
        target.pixel_x <= px;
        target.pixel_y <= py;
        @(posedge clk);
        while (!target.ready)
            @(posedge clk);
        sb.note_target(px, py);
        @(negedge clk);
    endtask

    // Wait until every expected beat is back; the block has no state to
    // drain beyond that since every target yields an angle beat.
    task automatic drain();
        target.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic load_camera(logic [17:0] fx, logic [17:0] fy, logic [15:0] cx,
                               logic [15:0] cy, logic [19:0] k1, logic [19:0] k2,
                               logic [19:0] p1, logic [19:0] p2);
        write_reg(REG_FOCAL_X, 32'(fx));
        write_reg(REG_FOCAL_Y, 32'(fy));
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_DIST_K1, {{12{k1[19]}}, k1});
        write_reg(REG_DIST_K2, {{12{k2[19]}}, k2});
        write_reg(REG_DIST_P1, {{12{p1[19]}}, p1});
        write_reg(REG_DIST_P2, {{12{p2[19]}}, p2});
    endtask

    // Mostly pixels near the principal point, where the angles are small and
    // the polynomial is well behaved; some anywhere in the 16-bit range.
    function automatic logic [15:0] near(logic [15:0] ctr);
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = int'(ctr) + $urandom_range(0, 16000) - 8000;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_target(near(sb.cam.center_x), near(sb.cam.center_y));
        drain();
    endtask

    initial
    begin
        sb           = new();
        gaps_on      = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        target.valid   = 1'b0;
        target.pixel_x = '0;
        target.pixel_y = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at reset settings: center, corners, field extremes.
        send_target(16'd10240, 16'd5760);
        send_target(16'd0, 16'd0);
        send_target(16'hFFFF, 16'hFFFF);
        send_target(16'd0, 16'hFFFF);
        send_target(16'hFFFF, 16'd0);
        send_target(16'h5555, 16'hAAAA);
        send_target(16'hAAAA, 16'h5555);
        drain();

        // Focal length of zero and just under the minimum are used as FOCAL_MIN,
        // which drives the normalised coordinates into saturation and
        // the radius past its clamp; big coefficients make huge tangents.
        load_camera(18'd0, 18'd15, 16'd0, 16'hFFFF, 20'h7FFFF, 20'h80000,
                    20'h7FFFF, 20'h80000);
        send_target(16'hFFFF, 16'd0);
        send_target(16'd0, 16'hFFFF);
        send_target(16'd1, 16'hFFFE);
        send_target(16'd0, 16'd0);
        drain();
        load_camera(18'h3FFFF, 18'h3FFFF, 16'hFFFF, 16'd0, 20'h80000, 20'h7FFFF,
                    20'h80000, 20'h7FFFF);
        send_target(16'd0, 16'hFFFF);
        send_target(16'hFFFF, 16'd0);
        send_target(16'd32768, 16'd32768);
        drain();
        load_camera(18'd16, 18'd16, 16'd32768, 16'd32768, 20'd0, 20'd0, 20'd0, 20'd0);
        send_target(16'd32768, 16'd32768);
        send_target(16'd32769, 16'd32767);
        send_target(16'd32800, 16'd32700);
        drain();

        // Random camera settings, each with a block of random targets.
        gaps_on = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            load_camera(18'($urandom_range(16, 262143)), 18'($urandom_range(0, 262143)),
                        16'($urandom), 16'($urandom),
                        20'($urandom), 20'($urandom_range(0, 4000) - 2000),
                        20'($urandom), 20'($urandom_range(0, 4000) - 2000));
            random_phase(220);
        end

        // Last part: typical camera, no idling on either side.
        load_camera(18'd16384, 18'd16384, 16'd10240, 16'd5760,
                    20'h0F000, 20'hFF000, 20'h00100, 20'hFFF00);
        gaps_on = 1'b0;
        random_phase(240);

        repeat (60)
            @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("pixel_to_view_angle_tb: done, clean");
        else
            $display("pixel_to_view_angle_tb: done, errors");
        $finish;
    end

endmodule
